// ----- rtl/core/two_source_pixel_channel_ratio_macros.svh -----
// Assertion macros shared by the checker
`ifndef TWO_SOURCE_PIXEL_CHANNEL_RATIO_MACROS_SVH
`define TWO_SOURCE_PIXEL_CHANNEL_RATIO_MACROS_SVH

// same-cycle implication
`define TSPCR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tspcr assertion failed");

// next-cycle implication
`define TSPCR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tspcr assertion failed");

`endif

// ----- rtl/core/tspcr_pkg.sv -----
`default_nettype none
package tspcr_pkg;

	localparam int QUO_W = 9;
	localparam int NUM_W = 17;
	localparam int DEN_W = 16;

	localparam logic [3:0] MODE_RATIO    = 4'd1;
	localparam logic [3:0] MODE_INV      = 4'd2;
	localparam logic [3:0] MODE_OFFS     = 4'd3;
	localparam logic [3:0] MODE_WSUM     = 4'd4;
	localparam logic [3:0] MODE_WSUM_DW  = 4'd5;
	localparam logic [3:0] MODE_PROD     = 4'd6;
	localparam logic [3:0] MODE_RATIO_S  = 4'd7;
	localparam logic [3:0] MODE_INV_S    = 4'd8;
	localparam logic [3:0] MODE_OFFS_S   = 4'd9;
	localparam logic [3:0] MODE_WSUM_S   = 4'd10;
	localparam logic [3:0] MODE_WSUM_DWS = 4'd11;
	localparam logic [3:0] MODE_PROD_S   = 4'd12;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_RED   = 2'd1;
	localparam logic [1:0] REG_GREEN = 2'd2;
	localparam logic [1:0] REG_BLUE  = 2'd3;

	typedef struct packed {
		logic [7:0] first_red;
		logic [7:0] first_green;
		logic [7:0] first_blue;
		logic [7:0] second_red;
		logic [7:0] second_green;
		logic [7:0] second_blue;
	} tspcr_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} tspcr_out_t;

	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic             zero;
		logic             ovf;
		logic             bypass;
		logic [7:0]       own;
		logic [3:0]       mode;
		logic [7:0]       wc;
		logic [15:0]      addend;
	} tspcr_lane_t;

endpackage
`default_nettype wire

// ----- rtl/core/tspcr_front.sv -----
`default_nettype none
module tspcr_front (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [3:0]            mode,
	input  wire logic [7:0]            own2,
	input  wire logic [7:0]            wc,
	input  wire logic [7:0]            fa,
	input  wire logic [7:0]            wa,
	input  wire logic [7:0]            fb,
	input  wire logic [7:0]            wb,
	output tspcr_pkg::tspcr_lane_t     lane_s1
);

	tspcr_pkg::tspcr_lane_t lane_d;
	logic        weighted;
	logic [8:0]  pa, pb, s;
	logic [9:0]  psum;
	logic [16:0] prod_a, prod_b, prod_s, wsum;

	always_comb begin
		weighted = (mode == tspcr_pkg::MODE_RATIO) || (mode == tspcr_pkg::MODE_INV) ||
			(mode == tspcr_pkg::MODE_RATIO_S) || (mode == tspcr_pkg::MODE_INV_S);
		pa = {1'b0, fa} + (weighted ? {1'b0, wa} : 9'd1);
		pb = {1'b0, fb} + (weighted ? {1'b0, wb} : 9'd1);
		s  = {1'b0, own2} + (weighted ? {1'b0, wc} : 9'd1);
		psum = {1'b0, pa} + {1'b0, pb};
		prod_a = {8'b0, pa} * {9'b0, wa};
		prod_b = {8'b0, pb} * {9'b0, wb};
		prod_s = {8'b0, s} * {9'b0, wc};
		wsum = prod_a + prod_b;

		lane_d = '0;
		lane_d.own = own2;
		lane_d.mode = mode;
		lane_d.wc = wc;
		lane_d.bypass = (mode < tspcr_pkg::MODE_RATIO) || (mode > tspcr_pkg::MODE_PROD_S);
		case (mode)
			tspcr_pkg::MODE_RATIO, tspcr_pkg::MODE_RATIO_S: begin
				lane_d.rem = {8'b0, s};
				lane_d.den = {6'b0, psum};
			end
			tspcr_pkg::MODE_INV, tspcr_pkg::MODE_INV_S,
			tspcr_pkg::MODE_OFFS, tspcr_pkg::MODE_OFFS_S: begin
				lane_d.rem = {7'b0, psum};
				lane_d.den = {7'b0, s};
			end
			tspcr_pkg::MODE_WSUM, tspcr_pkg::MODE_WSUM_S: begin
				lane_d.rem = wsum;
				lane_d.den = {7'b0, s};
			end
			tspcr_pkg::MODE_WSUM_DW, tspcr_pkg::MODE_WSUM_DWS: begin
				lane_d.rem = wsum;
				lane_d.den = prod_s[15:0];
			end
			tspcr_pkg::MODE_PROD, tspcr_pkg::MODE_PROD_S: begin
				lane_d.rem = prod_s;
				lane_d.den = prod_a[15:0];
				lane_d.addend = prod_b[15:0];
			end
			default: begin
				lane_d.rem = '0;
				lane_d.den = 16'd1;
			end
		endcase
		lane_d.zero = (lane_d.den == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= lane_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tspcr_div_stage.sv -----
`default_nettype none
module tspcr_div_stage #(
	parameter int HI = 8
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire tspcr_pkg::tspcr_lane_t lane_i,
	output tspcr_pkg::tspcr_lane_t     lane_o
);

	localparam int W = tspcr_pkg::DEN_W + tspcr_pkg::QUO_W + 1;

	tspcr_pkg::tspcr_lane_t lane_d;
	logic [W-1:0] r;
	logic [W-1:0] dsh;

	always_comb begin
		lane_d = lane_i;
		r = {{(W-tspcr_pkg::NUM_W){1'b0}}, lane_i.rem};
		dsh = '0;
		if (HI == tspcr_pkg::QUO_W - 1) begin
			lane_d.ovf = r >= {1'b0, lane_i.den, {tspcr_pkg::QUO_W{1'b0}}};
		end
		for (int j = 0; j < 3; j++) begin
			dsh = {{(W-tspcr_pkg::DEN_W){1'b0}}, lane_i.den} << (HI - j);
			if (r >= dsh) begin
				r = r - dsh;
				lane_d.quo[HI - j] = 1'b1;
			end
		end
		lane_d.rem = r[tspcr_pkg::NUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_o <= lane_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/tspcr_back.sv -----
`default_nettype none
module tspcr_back (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire tspcr_pkg::tspcr_lane_t lane_i,
	output logic [7:0]                 res_s5
);

	logic [8:0]  q;
	logic [16:0] base;
	logic [8:0]  sat;
	logic [16:0] prod;
	logic [16:0] v;
	logic [7:0]  res_d;

	always_comb begin
		q = lane_i.ovf ? '1 : lane_i.quo;
		case (lane_i.mode)
			tspcr_pkg::MODE_OFFS, tspcr_pkg::MODE_OFFS_S:
				base = {8'b0, q} + {9'b0, lane_i.wc};
			tspcr_pkg::MODE_PROD, tspcr_pkg::MODE_PROD_S:
				base = {8'b0, q} + {1'b0, lane_i.addend};
			default:
				base = {8'b0, q};
		endcase
		sat = (base > 17'd255) ? 9'd256 : base[8:0];
		prod = {8'b0, sat} * {9'b0, lane_i.wc};
		v = (lane_i.mode >= tspcr_pkg::MODE_RATIO_S) ? prod : {8'b0, sat};
		if (lane_i.bypass) begin
			res_d = lane_i.own;
		end else if (lane_i.zero || v > 17'd255) begin
			res_d = 8'd255;
		end else begin
			res_d = v[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s5 <= res_d;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/two_source_pixel_channel_ratio.sv -----
// channel   valid      stall      payload
// in        in_valid   in_stall   in_data  (tspcr_in_t)
// out       out_valid  out_stall  out_data (tspcr_out_t)
// cfg       cfg_we     -          cfg_index, cfg_data
//
// One pixel a cycle when not stalled; operand stage, three divider
// stages of three quotient bits each, then the scaling and clamp stage.
// Reset clears the valid bits and the registers; payload carries no reset.
// A stalled result holds the whole pipeline; in_stall follows it.
`default_nettype none
module two_source_pixel_channel_ratio (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire tspcr_pkg::tspcr_in_t in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output tspcr_pkg::tspcr_out_t     out_data,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [3:0] mode_q;
	logic [7:0] red_q, green_q, blue_q;
	logic       adv;
	logic       v_s1, v_s2, v_s3, v_s4;
	tspcr_pkg::tspcr_lane_t lane_s1 [3];
	tspcr_pkg::tspcr_lane_t lane_s2 [3];
	tspcr_pkg::tspcr_lane_t lane_s3 [3];
	tspcr_pkg::tspcr_lane_t lane_s4 [3];
	logic [7:0] res_s5 [3];

	assign adv = !out_valid || !out_stall;
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			red_q <= '0;
			green_q <= '0;
			blue_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tspcr_pkg::REG_MODE:  mode_q <= cfg_data[3:0];
				tspcr_pkg::REG_RED:   red_q <= cfg_data;
				tspcr_pkg::REG_GREEN: green_q <= cfg_data;
				tspcr_pkg::REG_BLUE:  blue_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	tspcr_front u_front_r (
		.clk(clk), .en(adv), .mode(mode_q), .own2(in_data.second_red), .wc(red_q),
		.fa(in_data.first_green), .wa(green_q), .fb(in_data.first_blue), .wb(blue_q),
		.lane_s1(lane_s1[0])
	);
	tspcr_front u_front_g (
		.clk(clk), .en(adv), .mode(mode_q), .own2(in_data.second_green), .wc(green_q),
		.fa(in_data.first_red), .wa(red_q), .fb(in_data.first_blue), .wb(blue_q),
		.lane_s1(lane_s1[1])
	);
	tspcr_front u_front_b (
		.clk(clk), .en(adv), .mode(mode_q), .own2(in_data.second_blue), .wc(blue_q),
		.fa(in_data.first_red), .wa(red_q), .fb(in_data.first_green), .wb(green_q),
		.lane_s1(lane_s1[2])
	);

	for (genvar c = 0; c < 3; c++) begin : g_lane
		tspcr_div_stage #(.HI(8)) u_div_a (
			.clk(clk), .en(adv), .lane_i(lane_s1[c]), .lane_o(lane_s2[c])
		);
		tspcr_div_stage #(.HI(5)) u_div_b (
			.clk(clk), .en(adv), .lane_i(lane_s2[c]), .lane_o(lane_s3[c])
		);
		tspcr_div_stage #(.HI(2)) u_div_c (
			.clk(clk), .en(adv), .lane_i(lane_s3[c]), .lane_o(lane_s4[c])
		);
		tspcr_back u_back (
			.clk(clk), .en(adv), .lane_i(lane_s4[c]), .res_s5(res_s5[c])
		);
	end

	assign out_data.out_red = res_s5[0];
	assign out_data.out_green = res_s5[1];
	assign out_data.out_blue = res_s5[2];

endmodule
`default_nettype wire

// ----- rtl/core/tspcr_checker.sv -----
`default_nettype none
`include "two_source_pixel_channel_ratio_macros.svh"
module tspcr_checker (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_stall,
	input  wire logic                  out_valid,
	input  wire logic                  out_stall,
	input  wire tspcr_pkg::tspcr_out_t out_data
);

	sequence acc_then_run;
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
			##1 !out_stall;
	endsequence

	`TSPCR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`TSPCR_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(out_data))
	`TSPCR_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`TSPCR_ASSERT_NXT(a_latency, clk, arst_n, acc_then_run, out_valid)

endmodule

bind two_source_pixel_channel_ratio tspcr_checker u_tspcr_checker (.*);
`default_nettype wire

// ----- dv/tb.sv -----
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	tspcr_pkg::tspcr_in_t in_data;
	logic out_valid;
	logic out_stall;
	tspcr_pkg::tspcr_out_t out_data;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	two_source_pixel_channel_ratio dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [3:0] cur_mode;
	logic [7:0] wt_red;
	logic [7:0] wt_green;
	logic [7:0] wt_blue;
	tspcr_pkg::tspcr_out_t pending_pixels[$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("tb: errors");
		$finish;
	end

	function automatic logic [7:0] mix_channel(logic [3:0] m, logic [7:0] own2,
			logic [7:0] wc, logic [7:0] fa, logic [7:0] wa, logic [7:0] fb,
			logic [7:0] wb);
		logic weighted;
		longint unsigned pa, pb, s, den, v;
		weighted = (m == tspcr_pkg::MODE_RATIO || m == tspcr_pkg::MODE_INV ||
			m == tspcr_pkg::MODE_RATIO_S || m == tspcr_pkg::MODE_INV_S);
		pa = fa + (weighted ? wa : 8'd1);
		pb = fb + (weighted ? wb : 8'd1);
		s = own2 + (weighted ? wc : 8'd1);
		v = own2;
		case (m)
			tspcr_pkg::MODE_RATIO, tspcr_pkg::MODE_RATIO_S: begin
				den = pa + pb;
				if (den == 0) return 8'hff;
				v = s / den;
				if (m == tspcr_pkg::MODE_RATIO_S) v = v * wc;
			end
			tspcr_pkg::MODE_INV, tspcr_pkg::MODE_INV_S: begin
				if (s == 0) return 8'hff;
				v = (pa + pb) / s;
				if (m == tspcr_pkg::MODE_INV_S) v = v * wc;
			end
			tspcr_pkg::MODE_OFFS, tspcr_pkg::MODE_OFFS_S: begin
				v = wc + (pa + pb) / s;
				if (m == tspcr_pkg::MODE_OFFS_S) v = v * wc;
			end
			tspcr_pkg::MODE_WSUM, tspcr_pkg::MODE_WSUM_S: begin
				v = (pa * wa + pb * wb) / s;
				if (m == tspcr_pkg::MODE_WSUM_S) v = v * wc;
			end
			tspcr_pkg::MODE_WSUM_DW, tspcr_pkg::MODE_WSUM_DWS: begin
				den = s * wc;
				if (den == 0) return 8'hff;
				v = (pa * wa + pb * wb) / den;
				if (m == tspcr_pkg::MODE_WSUM_DWS) v = v * wc;
			end
			tspcr_pkg::MODE_PROD, tspcr_pkg::MODE_PROD_S: begin
				den = pa * wa;
				if (den == 0) return 8'hff;
				v = (s * wc) / den + pb * wb;
				if (m == tspcr_pkg::MODE_PROD_S) v = v * wc;
			end
			default: v = own2;
		endcase
		return (v > 255) ? 8'hff : v[7:0];
	endfunction

	function automatic tspcr_pkg::tspcr_out_t blend_pixel(tspcr_pkg::tspcr_in_t px);
		tspcr_pkg::tspcr_out_t r;
		if (cur_mode < tspcr_pkg::MODE_RATIO || cur_mode > tspcr_pkg::MODE_PROD_S) begin
			r.out_red = px.second_red;
			r.out_green = px.second_green;
			r.out_blue = px.second_blue;
		end else begin
			r.out_red = mix_channel(cur_mode, px.second_red, wt_red, px.first_green,
				wt_green, px.first_blue, wt_blue);
			r.out_green = mix_channel(cur_mode, px.second_green, wt_green, px.first_red,
				wt_red, px.first_blue, wt_blue);
			r.out_blue = mix_channel(cur_mode, px.second_blue, wt_blue, px.first_red,
				wt_red, px.first_green, wt_green);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		tspcr_pkg::tspcr_out_t exp_px;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_pixels.size() == 0) begin
					$display("%0t unexpected pixel: expected none, actual %h", $realtime,
						out_data);
					errors++;
				end else begin
					exp_px = pending_pixels.pop_front();
					if (exp_px.out_red !== out_data.out_red) begin
						$display("%0t red: expected %h, actual %h", $realtime,
							exp_px.out_red, out_data.out_red);
						errors++;
					end
					if (exp_px.out_green !== out_data.out_green) begin
						$display("%0t green: expected %h, actual %h", $realtime,
							exp_px.out_green, out_data.out_green);
						errors++;
					end
					if (exp_px.out_blue !== out_data.out_blue) begin
						$display("%0t blue: expected %h, actual %h", $realtime,
							exp_px.out_blue, out_data.out_blue);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic send_pixel(tspcr_pkg::tspcr_in_t px);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_pixels.push_back(blend_pixel(px));
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			tspcr_pkg::REG_MODE: cur_mode = val[3:0];
			tspcr_pkg::REG_RED: wt_red = val;
			tspcr_pkg::REG_GREEN: wt_green = val;
			tspcr_pkg::REG_BLUE: wt_blue = val;
			default: ;
		endcase
	endtask

	task automatic drain_pipe();
		int n;
		in_valid <= 1'b0;
		n = 0;
		while (pending_pixels.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (10) @(posedge clk);
	endtask

	task automatic set_blend(logic [3:0] m, logic [7:0] r, logic [7:0] g,
			logic [7:0] b);
		drain_pipe();
		write_reg(tspcr_pkg::REG_MODE, {4'd0, m});
		write_reg(tspcr_pkg::REG_RED, r);
		write_reg(tspcr_pkg::REG_GREEN, g);
		write_reg(tspcr_pkg::REG_BLUE, b);
		cfg_we <= 1'b0;
	endtask

	function automatic tspcr_pkg::tspcr_in_t rand_pixel();
		tspcr_pkg::tspcr_in_t px;
		px = 48'({$urandom, $urandom});
		case ($urandom_range(3))
			0: px.second_red = $urandom_range(1) ? 8'h00 : 8'hff;
			1: px.first_green = $urandom_range(1) ? 8'h00 : 8'hff;
			default: ;
		endcase
		return px;
	endfunction

	task automatic test_bypass_reset();
		send_pixel('0);
		send_pixel('1);
		send_pixel(48'h123456_abcdef);
		set_blend(4'd13, 8'h55, 8'haa, 8'h0f);
		send_pixel(48'hfedcba_987654);
		set_blend(4'd15, 8'hff, 8'hff, 8'hff);
		send_pixel(rand_pixel());
	endtask

	task automatic test_modes_directed();
		for (int m = 1; m <= 12; m++) begin
			set_blend(m[3:0], 8'd0, 8'd0, 8'd0);
			send_pixel('0);
			set_blend(m[3:0], 8'hff, 8'hff, 8'hff);
			send_pixel('1);
		end
	endtask

	task automatic test_random(int count);
		logic [7:0] wr, wg, wb;
		for (int p = 0; p < count / 50; p++) begin
			wr = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255));
			wg = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(8));
			wb = ($urandom_range(4) == 0) ? 8'hff : 8'($urandom_range(255));
			set_blend(4'($urandom_range(15)), wr, wg, wb);
			for (int i = 0; i < 50; i++) send_pixel(rand_pixel());
		end
	endtask

	initial begin
		errors = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_mode = 4'd0;
		wt_red = 8'd0;
		wt_green = 8'd0;
		wt_blue = 8'd0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = tspcr_pkg::REG_MODE;
		cfg_data = 8'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass_reset();
		test_modes_directed();
		test_random(300);
		send_idle_pct = 67;
		test_random(300);
		send_idle_pct = 0;
		recv_stall_pct = 67;
		test_random(300);
		send_idle_pct = 13;
		recv_stall_pct = 13;
		test_random(350);
		drain_pipe();
		if (errors == 0 && pending_pixels.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end
endmodule
`default_nettype wire
